@@ rtl/core/swgcr_pkg.sv @@
// Shared types, codes and lookup tables for the sine wave glyph column renderer.
package swgcr_pkg;

   localparam int CmdDepthDefault = 4;
   localparam int RspDepthDefault = 4;

   localparam logic [1:0] KIND_START_FRAME = 2'd0;
   localparam logic [1:0] KIND_CHARACTER   = 2'd1;
   localparam logic [1:0] KIND_END_FRAME   = 2'd2;

   localparam logic [1:0] CSR_SCREEN_WIDTH = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP   = 2'd1;

   localparam logic [7:0] SCREEN_WIDTH_RESET = 8'd128;
   localparam logic [6:0] PHASE_STEP_RESET   = 7'd2;

   localparam logic [2:0] SPACING_COL = 3'd0;
   localparam logic [2:0] FINAL_COL   = 3'd5;

   typedef enum logic [1:0] {
      OP_START,
      OP_CHAR,
      OP_END
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] char_code;
      logic [2:0] skip_columns;
   } req_type;

   typedef struct packed {
      logic [31:0] column_bits;
      logic [6:0]  column_x;
      logic        last;
   } rsp_type;

   // Classified request: glyph columns packed with column 1 in the top byte.
   typedef struct packed {
      op_type      op;
      logic [39:0] glyph;
      logic [2:0]  skip;
   } cmd_type;

   typedef struct packed {
      logic [7:0] screen_width;
      logic [6:0] phase_step;
   } cfg_type;

   function automatic logic [7:0] quarter_wave(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'hCB;
         4'd1:    val = 8'hAA;
         4'd2:    val = 8'h99;
         4'd3:    val = 8'h88;
         4'd4:    val = 8'h77;
         4'd5:    val = 8'h66;
         4'd6:    val = 8'h55;
         4'd7:    val = 8'h44;
         4'd8:    val = 8'h33;
         4'd9:    val = 8'h32;
         4'd10:   val = 8'h22;
         4'd11:   val = 8'h11;
         4'd12:   val = 8'h11;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Quarter-wave nibble table mirrored in phase and in amplitude.
   function automatic logic [4:0] sine_offset(input logic [6:0] phase);
      logic [4:0] q;
      logic [7:0] pair;
      logic [4:0] nib;
      q = phase[4:0];
      if (phase[5]) begin
         q = 5'h1F - q;
      end
      pair = quarter_wave(q[4:1]);
      nib  = q[0] ? {1'b0, pair[3:0]} : {1'b0, pair[7:4]};
      if (phase[6]) begin
         nib = 5'h17 - nib;
      end
      return nib;
   endfunction

   function automatic logic [39:0] glyph_row(input logic [5:0] glyph);
      logic [39:0] row;
      case (glyph)
         6'd0:    row = 40'h00_00_00_00_00;
         6'd1:    row = 40'h00_00_2F_00_00;
         6'd2:    row = 40'h00_07_00_07_00;
         6'd3:    row = 40'h14_7F_14_7F_14;
         6'd4:    row = 40'h24_2A_7F_2A_12;
         6'd5:    row = 40'h23_13_08_64_62;
         6'd6:    row = 40'h36_49_55_22_50;
         6'd7:    row = 40'h00_05_03_00_00;
         6'd8:    row = 40'h00_1C_22_41_00;
         6'd9:    row = 40'h00_41_22_1C_00;
         6'd10:   row = 40'h14_08_3E_08_14;
         6'd11:   row = 40'h08_08_3E_08_08;
         6'd12:   row = 40'h00_00_A0_60_00;
         6'd13:   row = 40'h08_08_08_08_08;
         6'd14:   row = 40'h00_60_60_00_00;
         6'd15:   row = 40'h20_10_08_04_02;
         6'd16:   row = 40'h3E_51_49_45_3E;
         6'd17:   row = 40'h00_42_7F_40_00;
         6'd18:   row = 40'h42_61_51_49_46;
         6'd19:   row = 40'h21_41_45_4B_31;
         6'd20:   row = 40'h18_14_12_7F_10;
         6'd21:   row = 40'h27_45_45_45_39;
         6'd22:   row = 40'h3C_4A_49_49_30;
         6'd23:   row = 40'h01_71_09_05_03;
         6'd24:   row = 40'h36_49_49_49_36;
         6'd25:   row = 40'h06_49_49_29_1E;
         6'd26:   row = 40'h00_36_36_00_00;
         6'd27:   row = 40'h00_56_36_00_00;
         6'd28:   row = 40'h08_14_22_41_00;
         6'd29:   row = 40'h14_14_14_14_14;
         6'd30:   row = 40'h00_41_22_14_08;
         6'd31:   row = 40'h02_01_51_09_06;
         6'd32:   row = 40'h32_49_59_51_3E;
         6'd33:   row = 40'h7C_12_11_12_7C;
         6'd34:   row = 40'h7F_49_49_49_36;
         6'd35:   row = 40'h3E_41_41_41_22;
         6'd36:   row = 40'h7F_41_41_22_1C;
         6'd37:   row = 40'h7F_49_49_49_41;
         6'd38:   row = 40'h7F_09_09_09_01;
         6'd39:   row = 40'h3E_41_49_49_7A;
         6'd40:   row = 40'h7F_08_08_08_7F;
         6'd41:   row = 40'h00_41_7F_41_00;
         6'd42:   row = 40'h20_40_41_3F_01;
         6'd43:   row = 40'h7F_08_14_22_41;
         6'd44:   row = 40'h7F_40_40_40_40;
         6'd45:   row = 40'h7F_02_0C_02_7F;
         6'd46:   row = 40'h7F_04_08_10_7F;
         6'd47:   row = 40'h3E_41_41_41_3E;
         6'd48:   row = 40'h7F_09_09_09_06;
         6'd49:   row = 40'h3E_41_51_21_5E;
         6'd50:   row = 40'h7F_09_19_29_46;
         6'd51:   row = 40'h46_49_49_49_31;
         6'd52:   row = 40'h01_01_7F_01_01;
         6'd53:   row = 40'h3F_40_40_40_3F;
         6'd54:   row = 40'h1F_20_40_20_1F;
         6'd55:   row = 40'h3F_40_38_40_3F;
         6'd56:   row = 40'h63_14_08_14_63;
         6'd57:   row = 40'h07_08_70_08_07;
         6'd58:   row = 40'h61_51_49_45_43;
         6'd59:   row = 40'h00_7F_41_41_00;
         6'd60:   row = 40'h02_04_08_10_20;
         6'd61:   row = 40'h00_41_41_7F_00;
         6'd62:   row = 40'h04_02_01_02_04;
         default: row = 40'h40_40_40_40_40;
      endcase
      return row;
   endfunction

endpackage

@@ rtl/core/swgcr_fifo.sv @@
// Small first-in first-out queue of registers with show-ahead read data.
module swgcr_fifo #(
   parameter int  Depth     = 4,
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type wr_data,
   output logic     full,
   input  logic     pop,
   output data_type rd_data,
   output logic     empty
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   data_type              mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == CountWidth'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/core/swgcr_front.sv @@
// Front end: accepts requests, classifies them and fetches the glyph row.
module swgcr_front (
   input  swgcr_pkg::req_type req_data,
   input  logic               push,
   input  logic               cmd_full,
   output swgcr_pkg::cmd_type cmd_data,
   output logic               cmd_push
);

   logic       known_kind;
   logic [5:0] glyph_idx;

   // Codes below the font wrap onto its upper half.
   assign glyph_idx = 6'(req_data.char_code - 7'd32);

   always_comb begin
      known_kind     = 1'b1;
      cmd_data.glyph = swgcr_pkg::glyph_row(glyph_idx);
      cmd_data.skip  = req_data.skip_columns;
      case (req_data.kind)
         swgcr_pkg::KIND_START_FRAME: cmd_data.op = swgcr_pkg::OP_START;
         swgcr_pkg::KIND_CHARACTER:   cmd_data.op = swgcr_pkg::OP_CHAR;
         swgcr_pkg::KIND_END_FRAME:   cmd_data.op = swgcr_pkg::OP_END;
         default: begin
            // Unused kind: accept and drop.
            cmd_data.op = swgcr_pkg::OP_END;
            known_kind  = 1'b0;
         end
      endcase
   end

   assign cmd_push = push && !cmd_full && known_kind;

endmodule

@@ rtl/core/swgcr_back.sv @@
// Back end: steps through the columns of each character request and renders them.
module swgcr_back (
   input  logic               clock,
   input  logic               reset,
   input  swgcr_pkg::cfg_type cfg,
   input  swgcr_pkg::cmd_type cmd_data,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   output swgcr_pkg::rsp_type rsp_data,
   output logic               rsp_push,
   input  logic               rsp_full
);

   logic [6:0] phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [2:0] skip_ff, skip_in;
   logic [2:0] col_ff, col_in;

   logic [7:0]  col_byte;
   logic [4:0]  offset;
   logic        at_end;
   logic        drop;
   logic        final_col;
   logic        width_reached;

   always_comb begin
      case (col_ff)
         3'd1:    col_byte = cmd_data.glyph[39:32];
         3'd2:    col_byte = cmd_data.glyph[31:24];
         3'd3:    col_byte = cmd_data.glyph[23:16];
         3'd4:    col_byte = cmd_data.glyph[15:8];
         3'd5:    col_byte = cmd_data.glyph[7:0];
         default: col_byte = 8'h00;
      endcase
   end

   assign offset        = swgcr_pkg::sine_offset(phase_ff);
   assign at_end        = (pos_ff >= cfg.screen_width);
   // At position zero the spacing column and the first skip-1 glyph columns go.
   assign drop          = (pos_ff == 8'd0) && (skip_ff > col_ff);
   assign final_col     = (col_ff == swgcr_pkg::FINAL_COL);
   assign width_reached = ({1'b0, pos_ff} + 9'd1) >= {1'b0, cfg.screen_width};

   always_comb begin
      rsp_data.column_bits = (col_ff == swgcr_pkg::SPACING_COL) ? 32'd0
                                                                : 32'(col_byte) << offset;
      rsp_data.column_x    = pos_ff[6:0];
      rsp_data.last        = final_col || width_reached;
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      col_in   = col_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      if (!cmd_empty) begin
         case (cmd_data.op)
            swgcr_pkg::OP_START: begin
               pos_in  = 8'd0;
               skip_in = cmd_data.skip;
               cmd_pop = 1'b1;
            end
            swgcr_pkg::OP_END: begin
               phase_in = phase_ff - cfg.phase_step;
               cmd_pop  = 1'b1;
            end
            swgcr_pkg::OP_CHAR: begin
               if (at_end) begin
                  // Screen is full: drop the rest of the character.
                  col_in  = swgcr_pkg::SPACING_COL;
                  cmd_pop = 1'b1;
               end else if (drop) begin
                  if (final_col) begin
                     col_in  = swgcr_pkg::SPACING_COL;
                     cmd_pop = 1'b1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
               end else if (!rsp_full) begin
                  rsp_push = 1'b1;
                  pos_in   = pos_ff + 8'd1;
                  phase_in = phase_ff + 7'd1;
                  if (rsp_data.last) begin
                     col_in  = swgcr_pkg::SPACING_COL;
                     cmd_pop = 1'b1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
               end
            end
            default: begin
               cmd_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         pos_ff   <= '0;
         skip_ff  <= '0;
         col_ff   <= swgcr_pkg::SPACING_COL;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         col_ff   <= col_in;
      end
   end

`ifndef SYNTHESIS
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= swgcr_pkg::FINAL_COL)
      else $error("column counter beyond final column");

   a_emit_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (pos_ff < cfg.screen_width))
      else $error("column emitted at or beyond screen width");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.last) |-> cmd_pop ##1 (col_ff == swgcr_pkg::SPACING_COL))
      else $error("character not retired after its last column");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (phase_ff == 7'($past(phase_ff) + 7'd1)))
      else $error("phase did not advance with an emitted column");
`endif

endmodule

@@ rtl/core/sine_wave_glyph_column_renderer.sv @@
// Top level of the sine wave glyph column renderer: queues, control registers, front and back.
// Path: with the sequencer idle, an accepted request passes through the command queue and
// then the response queue before its first column is visible; each dropped leading column
// delays it further. Throughput: the column sequencer handles one column slot per cycle
// while results do not back up, dropped slots included; a character has six slots, fewer
// once the screen end cuts it short; a frame start or end also passes through it, an unused kind never reaches it.
// Reset (synchronous): queues empty, phase, position and skip cleared, width 128, step 2.
module sine_wave_glyph_column_renderer #(
   parameter int CmdDepth = swgcr_pkg::CmdDepthDefault,
   parameter int RspDepth = swgcr_pkg::RspDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  swgcr_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output swgcr_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   swgcr_pkg::cfg_type cfg_ff, cfg_in;
   swgcr_pkg::cmd_type cmd_wr, cmd_rd;
   swgcr_pkg::rsp_type rsp_wr;
   logic               cmd_push, cmd_pop, cmd_empty;
   logic               rsp_push, rsp_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            swgcr_pkg::CSR_SCREEN_WIDTH: cfg_in.screen_width = csr_wdata;
            swgcr_pkg::CSR_PHASE_STEP:   cfg_in.phase_step   = csr_wdata[6:0];
            default:                     cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width <= swgcr_pkg::SCREEN_WIDTH_RESET;
         cfg_ff.phase_step   <= swgcr_pkg::PHASE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swgcr_front u_front (
      .req_data (req_data),
      .push     (push),
      .cmd_full (full),
      .cmd_data (cmd_wr),
      .cmd_push (cmd_push)
   );

   swgcr_fifo #(
      .Depth     (CmdDepth),
      .data_type (swgcr_pkg::cmd_type)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   swgcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_data  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_wr),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   swgcr_fifo #(
      .Depth     (RspDepth),
      .data_type (swgcr_pkg::rsp_type)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule
